FILE: design/vqi_pkg.sv
// ----------------------------------------------------------------------------
// vqi_pkg
// Shared types, widths and codes for the VLAN ingress qualifier.
// ----------------------------------------------------------------------------
package vqi_pkg;

  localparam int VLAN_COUNT  = 4096;
  localparam int COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int VLAN_W      = 12;
  localparam int MAC_W       = 48;
  localparam int REASON_W    = 4;
  localparam int OUT_CNT_W   = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int VIDX_W      = $clog2(VLAN_COUNT);
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VLAN_W:0]        VLAN_LIMIT = (VLAN_W + 1)'(VLAN_COUNT);
  localparam logic [VIDX_W-1:0]      VIDX_LAST  = VIDX_W'(VLAN_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = '1;
  localparam logic [MAC_W-1:0]       MAC_BCAST  = '1;

  typedef enum logic [REASON_W-1:0] {
    REASON_OK               = 4'd0,
    REASON_NO_ROLE          = 4'd1,
    REASON_DOWN             = 4'd2,
    REASON_NO_BRIDGE        = 4'd3,
    REASON_BRIDGE_DOWN      = 4'd4,
    REASON_TAG_ON_ACCESS    = 4'd5,
    REASON_ACCESS_MISMATCH  = 4'd6,
    REASON_UNTAGGED_TRUNK   = 4'd7,
    REASON_TRUNK_NOT_MEMBER = 4'd8,
    REASON_TAG_ON_L3        = 4'd9,
    REASON_UNKNOWN          = 4'd10
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L3_ENABLED  = 3'd0,
    REG_SWITCHPORT  = 3'd1,
    REG_ADMIN_UP    = 3'd2,
    REG_AC_ROLE     = 3'd3,
    REG_L2_MODE     = 3'd4,
    REG_ACCESS_VLAN = 3'd5,
    REG_GRE_TUNNEL  = 3'd6,
    REG_PORT_MAC    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AC_NONE        = 2'd0,
    AC_NO_BRIDGE   = 2'd1,
    AC_BRIDGE_DOWN = 2'd2,
    AC_BRIDGE_UP   = 2'd3
  } ac_role_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_TRUNK  = 2'd2,
    MODE_UNUSED = 2'd3
  } l2_mode_t;

  typedef enum logic {
    CMD_QUALIFY = 1'b0,
    CMD_MEMBER  = 1'b1
  } command_t;

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_DONE  = 1'b1
  } clr_state_t;

  typedef struct packed {
    reason_t             reason;
    logic [VLAN_W-1:0]   apply_vlan;
  } decision_t;

endpackage

FILE: design/vqi_in_if.sv
// ----------------------------------------------------------------------------
// vqi_in_if
// Input channel: frame qualify and membership write transactions.
// ----------------------------------------------------------------------------
interface vqi_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic                       frame_tagged;
  logic [vqi_pkg::VLAN_W-1:0] frame_vlan;
  logic [vqi_pkg::MAC_W-1:0]  dest_mac;
  logic                       member_bit;

  modport source (output valid, command, frame_tagged, frame_vlan, dest_mac, member_bit,
                  input ready);
  modport sink (input valid, command, frame_tagged, frame_vlan, dest_mac, member_bit,
                output ready);
endinterface

FILE: design/vqi_out_if.sv
// ----------------------------------------------------------------------------
// vqi_out_if
// Result channel: qualification decision and drop counters.
// ----------------------------------------------------------------------------
interface vqi_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accept;
  logic [vqi_pkg::REASON_W-1:0]  reason;
  logic [vqi_pkg::VLAN_W-1:0]    apply_vlan;
  logic [vqi_pkg::OUT_CNT_W-1:0] port_drops;
  logic [vqi_pkg::OUT_CNT_W-1:0] bridge_drops;

  modport source (output valid, accept, reason, apply_vlan, port_drops, bridge_drops,
                  input ready);
  modport sink (input valid, accept, reason, apply_vlan, port_drops, bridge_drops,
                output ready);
endinterface

FILE: design/vqi_cfg_if.sv
// ----------------------------------------------------------------------------
// vqi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vqi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vqi_pkg::CFG_IDX_W-1:0]  index;
  logic [vqi_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/vlan_ingress_qualifier_unit.sv
// ----------------------------------------------------------------------------
// vlan_ingress_qualifier_unit
// Per-port 802.1Q ingress qualification: classify stage, decision queue and
// drop counter stage.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_ch   | in        | valid / ready    | command, frame_tagged, frame_vlan,
//          |           |                  | dest_mac, member_bit
//  out_ch  | out       | valid / ready    | accept, reason, apply_vlan,
//          |           |                  | port_drops, bridge_drops
//  cfg_ch  | in        | valid / ready=1  | index, data
//
//  One transaction per cycle on in_ch while in_ch.ready is high; a frame
//  accepted on in_ch passes the classify register, the queue and the output
//  register before it is valid on out_ch. Membership writes give no result.
//  After reset every entry of the membership map is swept to zero with
//  in_ch.ready low; configuration writes are taken during the sweep.
//  A stalled out_ch fills the output register, then the two-entry queue,
//  then the classify stage before in_ch.ready drops.
// ----------------------------------------------------------------------------
module vlan_ingress_qualifier_unit (
  input  logic      clk,
  input  logic      rst_n,
  vqi_in_if.sink    in_ch,
  vqi_out_if.source out_ch,
  vqi_cfg_if.sink   cfg_ch
);

  logic               push_valid;
  logic               push_ready;
  vqi_pkg::decision_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  vqi_pkg::decision_t pop_data;

  vqi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vqi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vqi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: design/vqi_front.sv
// ----------------------------------------------------------------------------
// vqi_front
// Configuration registers, trunk membership map with clear sweep, and the
// classify stage that turns each frame into a decision for the queue.
// ----------------------------------------------------------------------------
module vqi_front (
  input  logic                clk,
  input  logic                rst_n,
  vqi_in_if.sink              in_ch,
  vqi_cfg_if.sink             cfg_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output vqi_pkg::decision_t  push_data
);

  logic                        l3_enabled_r;
  logic                        switchport_r;
  logic                        admin_up_r;
  logic [1:0]                  ac_role_r;
  logic [1:0]                  l2_mode_r;
  logic [vqi_pkg::VLAN_W-1:0]  access_vlan_r;
  logic                        gre_tunnel_r;
  logic [vqi_pkg::MAC_W-1:0]   port_mac_r;

  vqi_pkg::clr_state_t         state_r, state_nxt;
  logic [vqi_pkg::VIDX_W-1:0]  clr_addr_r;
  logic                        clearing;

  logic                        member_mem_r [vqi_pkg::VLAN_COUNT];
  logic                        mem_rd_r;
  logic                        mem_we;
  logic [vqi_pkg::VIDX_W-1:0]  mem_waddr;
  logic                        mem_wdata;

  logic                        s1_valid_r;
  vqi_pkg::reason_t            s1_reason_r;
  logic                        s1_trunk_r;
  logic                        s1_in_range_r;
  logic [vqi_pkg::VLAN_W-1:0]  s1_apply_r;

  logic                        in_acc;
  logic                        frame_acc;
  logic                        cmd_acc;
  logic                        in_range;
  logic                        s1_advance;
  vqi_pkg::reason_t            cls_reason;
  logic                        cls_trunk;
  logic [vqi_pkg::VLAN_W-1:0]  cls_apply;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l3_enabled_r  <= 1'b0;
      switchport_r  <= 1'b0;
      admin_up_r    <= 1'b0;
      ac_role_r     <= 2'd0;
      l2_mode_r     <= 2'd0;
      access_vlan_r <= '0;
      gre_tunnel_r  <= 1'b0;
      port_mac_r    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vqi_pkg::REG_L3_ENABLED:  l3_enabled_r  <= cfg_ch.data[0];
        vqi_pkg::REG_SWITCHPORT:  switchport_r  <= cfg_ch.data[0];
        vqi_pkg::REG_ADMIN_UP:    admin_up_r    <= cfg_ch.data[0];
        vqi_pkg::REG_AC_ROLE:     ac_role_r     <= cfg_ch.data[1:0];
        vqi_pkg::REG_L2_MODE:     l2_mode_r     <= cfg_ch.data[1:0];
        vqi_pkg::REG_ACCESS_VLAN: access_vlan_r <= cfg_ch.data[vqi_pkg::VLAN_W-1:0];
        vqi_pkg::REG_GRE_TUNNEL:  gre_tunnel_r  <= cfg_ch.data[0];
        vqi_pkg::REG_PORT_MAC:    port_mac_r    <= cfg_ch.data[vqi_pkg::MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // clear sweep state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vqi_pkg::CLR_SWEEP: if (clr_addr_r == vqi_pkg::VIDX_LAST) state_nxt = vqi_pkg::CLR_DONE;
      vqi_pkg::CLR_DONE:  state_nxt = vqi_pkg::CLR_DONE;
      default:            state_nxt = vqi_pkg::CLR_SWEEP;
    endcase
  end

  always_comb begin
    unique case (state_r)
      vqi_pkg::CLR_SWEEP: clearing = 1'b1;
      vqi_pkg::CLR_DONE:  clearing = 1'b0;
      default:            clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= vqi_pkg::CLR_SWEEP;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign s1_advance = s1_valid_r && push_ready;
  assign in_ch.ready = !clearing && (!s1_valid_r || push_ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cmd_acc     = in_acc && (in_ch.command == vqi_pkg::CMD_MEMBER);
  assign frame_acc   = in_acc && (in_ch.command == vqi_pkg::CMD_QUALIFY);
  assign in_range    = {1'b0, in_ch.frame_vlan} < vqi_pkg::VLAN_LIMIT;

  assign mem_we    = clearing || (cmd_acc && in_range);
  assign mem_waddr = clearing ? clr_addr_r : in_ch.frame_vlan[vqi_pkg::VIDX_W-1:0];
  assign mem_wdata = clearing ? 1'b0 : in_ch.member_bit;

  always_ff @(posedge clk) begin
    if (mem_we) member_mem_r[mem_waddr] <= mem_wdata;
    if (frame_acc) mem_rd_r <= member_mem_r[in_ch.frame_vlan[vqi_pkg::VIDX_W-1:0]];
  end

  // ordered qualification rules
  always_comb begin
    cls_reason = vqi_pkg::REASON_OK;
    cls_trunk  = 1'b0;
    cls_apply  = '0;
    if (!l3_enabled_r && !switchport_r) begin
      cls_reason = vqi_pkg::REASON_NO_ROLE;
    end else if (!admin_up_r) begin
      cls_reason = vqi_pkg::REASON_DOWN;
    end else if (ac_role_r != vqi_pkg::AC_NONE) begin
      unique case (ac_role_r)
        vqi_pkg::AC_NO_BRIDGE:   cls_reason = vqi_pkg::REASON_NO_BRIDGE;
        vqi_pkg::AC_BRIDGE_DOWN: cls_reason = vqi_pkg::REASON_BRIDGE_DOWN;
        default:                 cls_reason = vqi_pkg::REASON_OK;
      endcase
    end else if (l2_mode_r == vqi_pkg::MODE_ACCESS) begin
      if (access_vlan_r == '0) begin
        cls_reason = in_ch.frame_tagged ? vqi_pkg::REASON_TAG_ON_ACCESS : vqi_pkg::REASON_OK;
      end else if (!in_ch.frame_tagged) begin
        cls_apply = access_vlan_r;
      end else if (in_ch.frame_vlan != access_vlan_r) begin
        cls_reason = vqi_pkg::REASON_ACCESS_MISMATCH;
      end
    end else if (l2_mode_r == vqi_pkg::MODE_TRUNK) begin
      if (!in_ch.frame_tagged) begin
        cls_reason = vqi_pkg::REASON_UNTAGGED_TRUNK;
      end else begin
        cls_reason = vqi_pkg::REASON_TRUNK_NOT_MEMBER;
        cls_trunk  = 1'b1;
      end
    end else if (gre_tunnel_r && in_ch.frame_tagged) begin
      cls_apply = in_ch.frame_vlan;
    end else if (l3_enabled_r && in_ch.frame_tagged) begin
      cls_reason = vqi_pkg::REASON_TAG_ON_L3;
    end else if (l3_enabled_r &&
                 (in_ch.dest_mac == port_mac_r || in_ch.dest_mac == vqi_pkg::MAC_BCAST)) begin
      cls_reason = vqi_pkg::REASON_OK;
    end else begin
      cls_reason = vqi_pkg::REASON_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (frame_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc) begin
      s1_reason_r   <= cls_reason;
      s1_trunk_r    <= cls_trunk;
      s1_in_range_r <= in_range;
      s1_apply_r    <= cls_apply;
    end
  end

  // resolve trunk membership from the registered map read
  always_comb begin
    push_data.apply_vlan = s1_apply_r;
    if (s1_trunk_r) begin
      push_data.reason = (s1_in_range_r && mem_rd_r) ? vqi_pkg::REASON_OK
                                                     : vqi_pkg::REASON_TRUNK_NOT_MEMBER;
    end else begin
      push_data.reason = s1_reason_r;
    end
  end

  assign push_valid = s1_valid_r;

endmodule

FILE: design/vqi_queue.sv
// ----------------------------------------------------------------------------
// vqi_queue
// Short decision queue between the classify stage and the counter stage.
// ----------------------------------------------------------------------------
module vqi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  vqi_pkg::decision_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output vqi_pkg::decision_t  pop_data
);

  vqi_pkg::decision_t          entry_r [vqi_pkg::QUEUE_DEPTH];
  logic [vqi_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [vqi_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [vqi_pkg::QCNT_W-1:0]  count_r;
  logic                        push;
  logic                        pop;

  localparam logic [vqi_pkg::QPTR_W-1:0] PTR_LAST = vqi_pkg::QPTR_W'(vqi_pkg::QUEUE_DEPTH - 1);
  localparam logic [vqi_pkg::QCNT_W-1:0] CNT_FULL = vqi_pkg::QCNT_W'(vqi_pkg::QUEUE_DEPTH);

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: design/vqi_back.sv
// ----------------------------------------------------------------------------
// vqi_back
// Drop counters and the output register of the result channel.
// ----------------------------------------------------------------------------
module vqi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  vqi_pkg::decision_t  pop_data,
  vqi_out_if.source           out_ch
);

  logic [vqi_pkg::COUNT_WIDTH-1:0] port_cnt_r, port_cnt_nxt;
  logic [vqi_pkg::COUNT_WIDTH-1:0] bridge_cnt_r, bridge_cnt_nxt;
  logic                            out_valid_r;
  logic                            accept_r;
  vqi_pkg::reason_t                reason_r;
  logic [vqi_pkg::VLAN_W-1:0]      apply_r;
  logic [vqi_pkg::OUT_CNT_W-1:0]   port_out_r;
  logic [vqi_pkg::OUT_CNT_W-1:0]   bridge_out_r;
  logic                            pop;
  logic                            bump_port;
  logic                            bump_bridge;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    bump_port   = 1'b0;
    bump_bridge = 1'b0;
    case (pop_data.reason) inside
      vqi_pkg::REASON_DOWN, vqi_pkg::REASON_NO_BRIDGE, vqi_pkg::REASON_UNKNOWN:
        bump_port = 1'b1;
      vqi_pkg::REASON_BRIDGE_DOWN:
        bump_bridge = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    port_cnt_nxt   = port_cnt_r;
    bridge_cnt_nxt = bridge_cnt_r;
    if (bump_port && port_cnt_r != vqi_pkg::CNT_MAX)     port_cnt_nxt   = port_cnt_r + 1'b1;
    if (bump_bridge && bridge_cnt_r != vqi_pkg::CNT_MAX) bridge_cnt_nxt = bridge_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_cnt_r   <= '0;
      bridge_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        port_cnt_r   <= port_cnt_nxt;
        bridge_cnt_r <= bridge_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      accept_r     <= pop_data.reason == vqi_pkg::REASON_OK;
      reason_r     <= pop_data.reason;
      apply_r      <= pop_data.apply_vlan;
      port_out_r   <= vqi_pkg::OUT_CNT_W'(port_cnt_nxt);
      bridge_out_r <= vqi_pkg::OUT_CNT_W'(bridge_cnt_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accept       = accept_r;
  assign out_ch.reason       = reason_r;
  assign out_ch.apply_vlan   = apply_r;
  assign out_ch.port_drops   = port_out_r;
  assign out_ch.bridge_drops = bridge_out_r;

endmodule

FILE: design/vqi_checker.sv
// ----------------------------------------------------------------------------
// vqi_checker
// Port-level checks of the qualifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vqi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          accept,
  input logic [vqi_pkg::REASON_W-1:0]  reason,
  input logic [vqi_pkg::VLAN_W-1:0]    apply_vlan,
  input logic [vqi_pkg::OUT_CNT_W-1:0] port_drops,
  input logic [vqi_pkg::OUT_CNT_W-1:0] bridge_drops
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({accept, reason, apply_vlan, port_drops, bridge_drops}))
    else $error("result changed while stalled");

  a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> accept == (reason == vqi_pkg::REASON_OK))
    else $error("accept disagrees with reason");

  a_drop_no_vlan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !accept |-> apply_vlan == '0)
    else $error("dropped frame carries a VLAN");

  a_sweep_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during membership sweep");

endmodule

bind vlan_ingress_qualifier_unit vqi_checker u_vqi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .accept       (out_ch.accept),
  .reason       (out_ch.reason),
  .apply_vlan   (out_ch.apply_vlan),
  .port_drops   (out_ch.port_drops),
  .bridge_drops (out_ch.bridge_drops)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vlan_ingress_qualifier_unit. Queued frame and
// membership transactions are driven on the input channel while the port
// registers are reprogrammed between phases. A local model of the ingress
// rules predicts each decision and the drop counters, and the output channel
// is compared field by field. Both channels stall at random, in schedules.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vqi_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 34;

  typedef struct {
    command_t          cmd;
    logic              has_tag;
    logic [VLAN_W-1:0] vlan;
    logic [MAC_W-1:0]  dmac;
    logic              member;
  } ingress_item_t;

  typedef struct {
    logic                   accept;
    reason_t                reason;
    logic [VLAN_W-1:0]      apply_vlan;
    logic [OUT_CNT_W-1:0]   port_drops;
    logic [OUT_CNT_W-1:0]   bridge_drops;
  } verdict_t;

  typedef struct {
    logic              l3;
    logic              sw;
    logic              up;
    ac_role_t          ac;
    l2_mode_t          mode;
    logic [VLAN_W-1:0] avlan;
    logic              gre;
    logic [MAC_W-1:0]  mac;
  } port_setup_t;

  logic clk;
  logic rst_n;

  vqi_in_if  in_bus ();
  vqi_out_if out_bus ();
  vqi_cfg_if cfg_bus ();

  vlan_ingress_qualifier_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // port model
  logic                   reg_l3          = 1'b0;
  logic                   reg_switch      = 1'b0;
  logic                   reg_up          = 1'b0;
  ac_role_t               reg_ac          = AC_NONE;
  l2_mode_t               reg_mode        = MODE_NONE;
  logic [VLAN_W-1:0]      reg_access_vlan = '0;
  logic                   reg_gre         = 1'b0;
  logic [MAC_W-1:0]       reg_mac         = '0;
  bit                     trunk_map [VLAN_COUNT];
  logic [COUNT_WIDTH-1:0] port_drop_cnt   = '0;
  logic [COUNT_WIDTH-1:0] bridge_drop_cnt = '0;

  verdict_t      pending_verdicts [$];
  ingress_item_t frame_backlog [$];
  ingress_item_t cur_item;
  port_setup_t   stim_setup;
  logic [VLAN_W-1:0] hot_vlans [6];

  int issued_items    = 0;
  int accepted_items  = 0;
  int reg_writes      = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 36;
  int recv_idle_pct   = 73;
  logic hold_sender   = 1'b0;

  always #2 clk = ~clk;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [COUNT_WIDTH-1:0] bump_sat(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void load_port_reg(input cfg_reg_t idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_L3_ENABLED:  reg_l3          = data[0];
      REG_SWITCHPORT:  reg_switch      = data[0];
      REG_ADMIN_UP:    reg_up          = data[0];
      REG_AC_ROLE:     reg_ac          = ac_role_t'(data[1:0]);
      REG_L2_MODE:     reg_mode        = l2_mode_t'(data[1:0]);
      REG_ACCESS_VLAN: reg_access_vlan = data[VLAN_W-1:0];
      REG_GRE_TUNNEL:  reg_gre         = data[0];
      REG_PORT_MAC:    reg_mac         = data[MAC_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void classify_ingress(input ingress_item_t t);
    verdict_t v;
    v.reason     = REASON_OK;
    v.apply_vlan = '0;
    if (t.cmd == CMD_MEMBER) begin
      if (int'(t.vlan) < VLAN_COUNT) trunk_map[t.vlan] = t.member;
      return;
    end
    if (!reg_l3 && !reg_switch) begin
      v.reason = REASON_NO_ROLE;
    end else if (!reg_up) begin
      v.reason = REASON_DOWN;
      port_drop_cnt = bump_sat(port_drop_cnt);
    end else if (reg_ac != AC_NONE) begin
      if (reg_ac == AC_NO_BRIDGE) begin
        v.reason = REASON_NO_BRIDGE;
        port_drop_cnt = bump_sat(port_drop_cnt);
      end else if (reg_ac == AC_BRIDGE_DOWN) begin
        v.reason = REASON_BRIDGE_DOWN;
        bridge_drop_cnt = bump_sat(bridge_drop_cnt);
      end
    end else if (reg_mode == MODE_ACCESS) begin
      if (reg_access_vlan == '0) begin
        if (t.has_tag) v.reason = REASON_TAG_ON_ACCESS;
      end else if (!t.has_tag) begin
        v.apply_vlan = reg_access_vlan;
      end else if (t.vlan != reg_access_vlan) begin
        v.reason = REASON_ACCESS_MISMATCH;
      end
    end else if (reg_mode == MODE_TRUNK) begin
      if (!t.has_tag) v.reason = REASON_UNTAGGED_TRUNK;
      else if (!(int'(t.vlan) < VLAN_COUNT && trunk_map[t.vlan]))
        v.reason = REASON_TRUNK_NOT_MEMBER;
    end else if (reg_gre && t.has_tag) begin
      v.apply_vlan = t.vlan;
    end else if (reg_l3 && t.has_tag) begin
      v.reason = REASON_TAG_ON_L3;
    end else if (!(reg_l3 && (t.dmac == reg_mac || t.dmac == MAC_BCAST))) begin
      v.reason = REASON_UNKNOWN;
      port_drop_cnt = bump_sat(port_drop_cnt);
    end
    v.accept       = (v.reason == REASON_OK);
    v.port_drops   = port_drop_cnt[OUT_CNT_W-1:0];
    v.bridge_drops = bridge_drop_cnt[OUT_CNT_W-1:0];
    pending_verdicts.push_back(v);
  endfunction

  task automatic check_verdict();
    verdict_t v;
    if (pending_verdicts.size() == 0) begin
      note_mismatch("decision with no frame pending");
    end else begin
      v = pending_verdicts.pop_front();
      if (out_bus.accept !== v.accept)
        note_mismatch($sformatf("accept %0b, want %0b", out_bus.accept, v.accept));
      if (out_bus.reason !== v.reason)
        note_mismatch($sformatf("reason %0d, want %0d", out_bus.reason, v.reason));
      if (out_bus.apply_vlan !== v.apply_vlan)
        note_mismatch($sformatf("apply_vlan %0d, want %0d", out_bus.apply_vlan,
                                v.apply_vlan));
      if (out_bus.port_drops !== v.port_drops)
        note_mismatch($sformatf("port_drops %0d, want %0d", out_bus.port_drops,
                                v.port_drops));
      if (out_bus.bridge_drops !== v.bridge_drops)
        note_mismatch($sformatf("bridge_drops %0d, want %0d", out_bus.bridge_drops,
                                v.bridge_drops));
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && issued_items == accepted_items) begin
      if (hold_sender || frame_backlog.size() == 0 ||
          $urandom_range(99) < sender_idle_pct) begin
        in_bus.valid <= 1'b0;
      end else begin
        cur_item = frame_backlog.pop_front();
        issued_items++;
        in_bus.valid        <= 1'b1;
        in_bus.command      <= cur_item.cmd;
        in_bus.frame_tagged <= cur_item.has_tag;
        in_bus.frame_vlan   <= cur_item.vlan;
        in_bus.dest_mac     <= cur_item.dmac;
        in_bus.member_bit   <= cur_item.member;
      end
    end
  end

  // output stall
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        load_port_reg(cfg_reg_t'(cfg_bus.index), cfg_bus.data);
        reg_writes++;
      end
      if (out_bus.valid && out_bus.ready) check_verdict();
      if (in_bus.valid && in_bus.ready) begin
        classify_ingress(cur_item);
        accepted_items++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout, %0d decisions outstanding", pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic void push_frame(input logic tag_on, input logic [VLAN_W-1:0] vlan,
                                     input logic [MAC_W-1:0] dmac);
    ingress_item_t t;
    t = '{cmd: CMD_QUALIFY, has_tag: tag_on, vlan: vlan, dmac: dmac, member: 1'b0};
    frame_backlog.push_back(t);
  endfunction

  function automatic void push_member(input logic [VLAN_W-1:0] vlan, input logic bit_val);
    ingress_item_t t;
    t = '{cmd: CMD_MEMBER, has_tag: 1'b0, vlan: vlan, dmac: '0, member: bit_val};
    frame_backlog.push_back(t);
  endfunction

  task automatic drain_port();
    do @(negedge clk);
    while (frame_backlog.size() != 0 || issued_items != accepted_items ||
           pending_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    int target;
    target = reg_writes + 1;
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(negedge clk); while (reg_writes < target);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_port_cfg(input port_setup_t c);
    drain_port();
    write_reg(REG_L3_ENABLED,  CFG_DATA_W'(c.l3));
    write_reg(REG_SWITCHPORT,  CFG_DATA_W'(c.sw));
    write_reg(REG_ADMIN_UP,    CFG_DATA_W'(c.up));
    write_reg(REG_AC_ROLE,     CFG_DATA_W'(c.ac));
    write_reg(REG_L2_MODE,     CFG_DATA_W'(c.mode));
    write_reg(REG_ACCESS_VLAN, CFG_DATA_W'(c.avlan));
    write_reg(REG_GRE_TUNNEL,  CFG_DATA_W'(c.gre));
    write_reg(REG_PORT_MAC,    CFG_DATA_W'(c.mac));
    stim_setup = c;
  endtask

  function automatic port_setup_t random_setup();
    port_setup_t c;
    int pick;
    pick = $urandom_range(7);
    {c.l3, c.sw} = (pick == 0) ? 2'b00 : 2'($urandom_range(3, 1));
    c.up    = ($urandom_range(7) != 0);
    c.ac    = ($urandom_range(9) < 7) ? AC_NONE : ac_role_t'($urandom_range(3, 1));
    c.mode  = l2_mode_t'($urandom_range(3));
    c.avlan = ($urandom_range(3) == 0) ? '0 : hot_vlans[$urandom_range(5)];
    c.gre   = 1'($urandom_range(1));
    pick = $urandom_range(3);
    c.mac   = (pick == 0) ? '0 : (pick == 1) ? MAC_BCAST : rand_mac();
    return c;
  endfunction

  function automatic ingress_item_t random_item();
    ingress_item_t t;
    int pick;
    t.has_tag = ($urandom_range(9) < 6);
    t.member  = 1'($urandom_range(1));
    t.dmac    = rand_mac();
    pick = $urandom_range(9);
    t.vlan = (pick < 5) ? hot_vlans[$urandom_range(5)] :
             (pick < 7) ? stim_setup.avlan : VLAN_W'($urandom);
    if ($urandom_range(4) == 0) begin
      t.cmd = CMD_MEMBER;
    end else begin
      t.cmd = CMD_QUALIFY;
      pick = $urandom_range(19);
      if (pick < 5) t.dmac = stim_setup.mac;
      else if (pick < 7) t.dmac = MAC_BCAST;
    end
    return t;
  endfunction

  initial begin
    port_setup_t c;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = CMD_QUALIFY;
    in_bus.frame_tagged = 1'b0;
    in_bus.frame_vlan   = '0;
    in_bus.dest_mac     = '0;
    in_bus.member_bit   = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_L3_ENABLED;
    cfg_bus.data        = '0;
    c = '{l3: 1'b0, sw: 1'b0, up: 1'b0, ac: AC_NONE, mode: MODE_NONE,
          avlan: '0, gre: 1'b0, mac: '0};
    stim_setup = c;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    push_frame(1'b0, 12'd5, rand_mac());

    c.sw = 1'b1;
    apply_port_cfg(c);
    push_frame(1'b1, 12'd7, rand_mac());

    c.up = 1'b1;
    c.ac = AC_NO_BRIDGE;
    apply_port_cfg(c);
    push_frame(1'b0, 12'd0, rand_mac());
    c.ac = AC_BRIDGE_DOWN;
    apply_port_cfg(c);
    push_frame(1'b1, 12'd100, rand_mac());
    c.ac = AC_BRIDGE_UP;
    apply_port_cfg(c);
    push_frame(1'b1, 12'd4095, rand_mac());

    c.ac   = AC_NONE;
    c.mode = MODE_ACCESS;
    apply_port_cfg(c);
    push_frame(1'b1, 12'd0, rand_mac());
    push_frame(1'b0, 12'd33, rand_mac());
    c.avlan = 12'd4095;
    apply_port_cfg(c);
    push_frame(1'b0, 12'd0, rand_mac());
    push_frame(1'b1, 12'd4095, rand_mac());
    push_frame(1'b1, 12'd0, rand_mac());

    c.mode = MODE_TRUNK;
    apply_port_cfg(c);
    push_member(12'd4095, 1'b1);
    push_member(12'd0, 1'b1);
    push_frame(1'b1, 12'd4095, rand_mac());
    push_frame(1'b1, 12'd1, rand_mac());
    push_frame(1'b0, 12'd4095, rand_mac());
    push_member(12'd4095, 1'b0);
    push_frame(1'b1, 12'd4095, rand_mac());
    push_frame(1'b1, 12'd0, rand_mac());

    c = '{l3: 1'b1, sw: 1'b0, up: 1'b1, ac: AC_NONE, mode: MODE_UNUSED,
          avlan: 12'd4095, gre: 1'b1, mac: '0};
    apply_port_cfg(c);
    push_frame(1'b1, 12'd4095, rand_mac());
    c.gre = 1'b0;
    c.mac = 48'hA5C3_0F1E_7B29;
    apply_port_cfg(c);
    push_frame(1'b1, 12'd9, c.mac);
    push_frame(1'b0, 12'd9, c.mac);
    push_frame(1'b0, 12'd9, MAC_BCAST);
    push_frame(1'b0, 12'd9, 48'h5A3C_F0E1_84D6);

    c = '{l3: 1'b0, sw: 1'b1, up: 1'b1, ac: AC_NONE, mode: MODE_NONE,
          avlan: '0, gre: 1'b0, mac: MAC_BCAST};
    apply_port_cfg(c);
    push_frame(1'b0, 12'd0, MAC_BCAST);

    hot_vlans[0] = '0;
    hot_vlans[1] = '1;
    for (int i = 2; i < 6; i++) hot_vlans[i] = VLAN_W'($urandom);

    for (int sched = 0; sched < 3; sched++) begin
      drain_port();
      sender_idle_pct <= (sched == 0) ? 36 : (sched == 1) ? 73 : 0;
      recv_idle_pct   <= (sched == 0) ? 73 : (sched == 1) ? 36 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        apply_port_cfg(random_setup());
        for (int k = 0; k < PHASE_ITEMS; k++) frame_backlog.push_back(random_item());
        if (sched == 0 && ph == 0) begin
          do @(negedge clk); while (frame_backlog.size() > PHASE_ITEMS / 2);
          hold_sender <= 1'b1;
          do @(negedge clk);
          while (issued_items != accepted_items || pending_verdicts.size() != 0);
          hold_sender <= 1'b0;
        end
      end
    end

    drain_port();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
